// ===== hw/rtl/spoe_pkg.sv =====
`default_nettype none
package spoe_pkg;

  typedef enum logic [1:0] {
    OP_RELOAD = 2'd0,
    OP_SET_MODE = 2'd1,
    OP_NEXT = 2'd2,
    OP_PREV = 2'd3
  } opcode_t;

  localparam logic [1:0] CFG_LENGTH = 2'd0;
  localparam logic [1:0] CFG_START = 2'd1;
  localparam logic [1:0] CFG_GENERATION = 2'd2;
  localparam logic [1:0] CFG_SOURCE = 2'd3;

  localparam logic [31:0] SEED_BASE = 32'h6D2B79F5;
  localparam logic [31:0] MIX_LENGTH = 32'd2654435761;
  localparam logic [31:0] MIX_GENERATION = 32'd2246822519;
  localparam logic [31:0] MIX_SOURCE = 32'd3266489917;
  localparam logic [31:0] MIX_CURRENT = 32'd668265263;
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

endpackage
`default_nettype wire

// ===== hw/rtl/shuffle_play_order_engine_unit.sv =====
`default_nettype none
// Play-order engine. An item is taken when start is high and busy is low; its single result
// appears later for one cycle on done with status, track_index and order_position, and must
// be captured then since the receiver cannot stall it. Next and previous do one read of the
// order memory. A refused item answers in the cycle after it is taken. Reload and sequential
// set-mode do one memory write per track for a length L. A shuffle set-mode with L > 2 does
// the fill, four seed multiplies, and per swap one LCG step, a bit-serial modulo and two reads
// and two writes on the order memory.
module shuffle_play_order_engine_unit #(
  parameter int MAX_TRACKS = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode,
  input  wire logic        shuffle_on,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             done,
  output logic             status,
  output logic [8:0]       track_index,
  output logic [8:0]       order_position
);

  localparam int IW = $clog2(MAX_TRACKS);
  localparam int LW = $clog2(MAX_TRACKS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_SEED, S_LCG, S_DIV, S_RD_I, S_RD_J, S_WR_I, S_WR_J, S_NAV
  } state_t;

  state_t state;

  logic [9:0]  cfg_length;
  logic [8:0]  cfg_start;
  logic [31:0] cfg_generation;
  logic [31:0] cfg_source;

  logic [IW-1:0] current;
  logic [IW-1:0] position;
  logic [IW-1:0] nav_pos;
  logic [LW-1:0] length_in_use;
  logic          queue_loaded;
  logic          shuffle_active;
  logic [31:0]   held_generation;
  logic [31:0]   held_source;

  logic [IW-1:0] idx;
  logic [31:0]   x;
  logic [31:0]   quot;
  logic [IW-1:0] rem;
  logic [4:0]    div_cnt;
  logic [1:0]    seed_cnt;
  logic [IW-1:0] tmp;

  logic [IW-1:0] mem [MAX_TRACKS];
  logic [IW-1:0] rd_data;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [IW-1:0] mem_wd;
  logic [IW-1:0] mem_ra;

  logic [IW-1:0] fill_value;
  logic [31:0]   seed_op;
  logic [31:0]   seed_k;
  logic [31:0]   seed_prod;
  logic [IW:0]   rem_shift;
  logic [IW:0]   rem_sub;
  logic          rem_ge;
  logic [IW-1:0] rem_next;
  logic [IW-1:0] j_index;
  logic [IW-1:0] last_index;
  logic          next_ok;
  logic          prev_ok;
  logic          reload_ok;

  assign last_index = IW'(length_in_use - LW'(1));
  assign j_index = rem + IW'(1);
  assign next_ok = queue_loaded && ((LW+1)'(position) + (LW+1)'(1) < (LW+1)'(length_in_use));
  assign prev_ok = queue_loaded && (position != '0);
  assign reload_ok = (cfg_length != 10'd0) && (32'(cfg_length) <= 32'(MAX_TRACKS))
                     && (10'(cfg_start) < cfg_length);

  // In shuffle mode position 0 holds the current track and the others follow ascending.
  always_comb begin
    if (!shuffle_active) begin
      fill_value = idx;
    end else if (idx == '0) begin
      fill_value = current;
    end else if (idx <= current) begin
      fill_value = idx - IW'(1);
    end else begin
      fill_value = idx;
    end
  end

  always_comb begin
    case (seed_cnt)
      2'd0: begin
        seed_op = 32'(length_in_use);
        seed_k = spoe_pkg::MIX_LENGTH;
      end
      2'd1: begin
        seed_op = held_generation;
        seed_k = spoe_pkg::MIX_GENERATION;
      end
      2'd2: begin
        seed_op = held_source;
        seed_k = spoe_pkg::MIX_SOURCE;
      end
      default: begin
        seed_op = 32'(current) + 32'd1;
        seed_k = spoe_pkg::MIX_CURRENT;
      end
    endcase
    seed_prod = seed_op * seed_k;
  end

  always_comb begin
    rem_shift = {rem, quot[31]};
    rem_ge = rem_shift >= (IW+1)'(idx);
    rem_sub = rem_shift - (IW+1)'(idx);
    rem_next = rem_ge ? IW'(rem_sub) : IW'(rem_shift);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx;
    mem_wd = fill_value;
    case (state)
      S_FILL: mem_we = 1'b1;
      S_WR_I: begin
        mem_we = 1'b1;
        mem_wd = rd_data;
      end
      S_WR_J: begin
        mem_we = 1'b1;
        mem_wa = j_index;
        mem_wd = tmp;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_comb begin
    case (state)
      S_RD_I: mem_ra = idx;
      S_RD_J: mem_ra = j_index;
      default: mem_ra = (spoe_pkg::opcode_t'(opcode) == spoe_pkg::OP_NEXT)
                        ? position + IW'(1) : position - IW'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_length <= 10'd1;
      cfg_start <= 9'd0;
      cfg_generation <= 32'd0;
      cfg_source <= 32'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        spoe_pkg::CFG_LENGTH: cfg_length <= cfg_data[9:0];
        spoe_pkg::CFG_START: cfg_start <= cfg_data[8:0];
        spoe_pkg::CFG_GENERATION: cfg_generation <= cfg_data;
        default: cfg_source <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      status <= 1'b0;
      current <= '0;
      position <= '0;
      length_in_use <= '0;
      queue_loaded <= 1'b0;
      shuffle_active <= 1'b0;
      held_generation <= 32'd0;
      held_source <= 32'd0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          idx <= '0;
          if (start) begin
            case (spoe_pkg::opcode_t'(opcode))
              spoe_pkg::OP_RELOAD: begin
                if (reload_ok) begin
                  length_in_use <= LW'(cfg_length);
                  current <= IW'(cfg_start);
                  position <= IW'(cfg_start);
                  held_generation <= cfg_generation;
                  held_source <= cfg_source;
                  shuffle_active <= 1'b0;
                  queue_loaded <= 1'b1;
                  state <= S_FILL;
                end else begin
                  done <= 1'b1;
                  status <= 1'b1;
                end
              end
              spoe_pkg::OP_SET_MODE: begin
                if (queue_loaded) begin
                  shuffle_active <= shuffle_on;
                  position <= shuffle_on ? '0 : current;
                  state <= S_FILL;
                end else begin
                  done <= 1'b1;
                  status <= 1'b1;
                end
              end
              default: begin
                if ((spoe_pkg::opcode_t'(opcode) == spoe_pkg::OP_NEXT) ? next_ok : prev_ok) begin
                  nav_pos <= mem_ra;
                  state <= S_NAV;
                end else begin
                  done <= 1'b1;
                  status <= 1'b1;
                end
              end
            endcase
          end
        end
        S_NAV: begin
          current <= rd_data;
          position <= nav_pos;
          done <= 1'b1;
          status <= 1'b0;
          state <= S_IDLE;
        end
        S_FILL: begin
          if (idx == last_index) begin
            if (shuffle_active && length_in_use > LW'(2)) begin
              idx <= last_index;
              x <= spoe_pkg::SEED_BASE;
              seed_cnt <= 2'd0;
              state <= S_SEED;
            end else begin
              done <= 1'b1;
              status <= 1'b0;
              state <= S_IDLE;
            end
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_SEED: begin
          x <= x ^ seed_prod;
          seed_cnt <= seed_cnt + 2'd1;
          if (seed_cnt == 2'd3) begin
            state <= S_LCG;
          end
        end
        S_LCG: begin
          x <= x * spoe_pkg::LCG_MUL + spoe_pkg::LCG_ADD;
          state <= S_DIV;
          div_cnt <= 5'd0;
          rem <= '0;
          quot <= x * spoe_pkg::LCG_MUL + spoe_pkg::LCG_ADD;
        end
        S_DIV: begin
          rem <= rem_next;
          quot <= {quot[30:0], 1'b0};
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            state <= S_RD_I;
          end
        end
        S_RD_I: state <= S_RD_J;
        S_RD_J: begin
          tmp <= rd_data;
          state <= S_WR_I;
        end
        S_WR_I: state <= S_WR_J;
        S_WR_J: begin
          if (idx == IW'(2)) begin
            done <= 1'b1;
            status <= 1'b0;
            state <= S_IDLE;
          end else begin
            idx <= idx - IW'(1);
            state <= S_LCG;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign track_index = 9'(current);
  assign order_position = 9'(position);

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while still busy");
  a_accept_answers: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item neither started nor answered");
  a_ok_loaded: assert property (@(posedge clk) disable iff (rst)
    (done && !status) |-> queue_loaded)
    else $error("success reported with no queue loaded");
  a_nav_two: assert property (@(posedge clk) disable iff (rst)
    (state == S_NAV) |=> (done && !status))
    else $error("navigation result missing");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
module tb;

  class order_scoreboard;
    typedef struct packed {
      bit       st;
      bit [8:0] trk;
      bit [8:0] pos;
    } result_t;

    result_t   expected_q[$];
    int        errors;
    bit [9:0]  reg_len;
    bit [8:0]  reg_start;
    bit [31:0] reg_gen;
    bit [31:0] reg_src;
    bit [8:0]  order[512];
    bit [8:0]  cur;
    bit [8:0]  pos;
    bit        shuffled;
    bit        loaded;
    bit [9:0]  len;
    bit [31:0] gen;
    bit [31:0] src;

    function new();
      reg_len = 1;
      foreach (order[i]) order[i] = '0;
    endfunction

    function void write_reg(logic [1:0] idx, bit [31:0] d);
      case (idx)
        spoe_pkg::CFG_LENGTH: reg_len = d[9:0];
        spoe_pkg::CFG_START: reg_start = d[8:0];
        spoe_pkg::CFG_GENERATION: reg_gen = d;
        spoe_pkg::CFG_SOURCE: reg_src = d;
        default: ;
      endcase
    endfunction

    function void rebuild();
      int        n;
      int        w;
      bit [31:0] x;
      bit [31:0] j;
      bit [8:0]  t;
      n = len;
      if (shuffled) begin
        x = spoe_pkg::SEED_BASE ^ ({22'd0, len} * spoe_pkg::MIX_LENGTH)
            ^ (gen * spoe_pkg::MIX_GENERATION) ^ (src * spoe_pkg::MIX_SOURCE)
            ^ (({23'd0, cur} + 32'd1) * spoe_pkg::MIX_CURRENT);
        w = 0;
        order[w++] = cur;
        for (int i = 0; i < n; i++)
          if (i != cur && w < n) order[w++] = 9'(i);
        for (int i = n - 1; i > 1; i--) begin
          x = x * spoe_pkg::LCG_MUL + spoe_pkg::LCG_ADD;
          j = 32'd1 + (x % 32'(i));
          t = order[i];
          order[i] = order[j];
          order[j] = t;
        end
        pos = 0;
      end else begin
        for (int i = 0; i < n; i++) order[i] = 9'(i);
        pos = cur;
      end
    endfunction

    function void note_item(spoe_pkg::opcode_t op, bit sh);
      bit        fail;
      bit [9:0]  p;
      fail = 1;
      case (op)
        spoe_pkg::OP_RELOAD:
          if (reg_len != 0 && reg_len <= 512 && {1'b0, reg_start} < reg_len) begin
            len = reg_len;
            cur = reg_start;
            gen = reg_gen;
            src = reg_src;
            shuffled = 0;
            loaded = 1;
            rebuild();
            fail = 0;
          end
        spoe_pkg::OP_SET_MODE:
          if (loaded && len != 0) begin
            shuffled = sh;
            rebuild();
            fail = 0;
          end
        spoe_pkg::OP_NEXT: begin
          p = {1'b0, pos} + 10'd1;
          if (loaded && p < len) begin
            pos = p[8:0];
            cur = order[pos];
            fail = 0;
          end
        end
        default:
          if (loaded && pos != 0) begin
            pos = pos - 9'd1;
            cur = order[pos];
            fail = 0;
          end
      endcase
      expected_q.push_back({fail, cur, pos});
    endfunction

    function void check_result(bit st, bit [8:0] trk, bit [8:0] p);
      result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no item outstanding: status %0d track %0d position %0d",
               st, trk, p);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.st) begin
        $error("status: expected %0d, got %0d", e.st, st);
        errors++;
      end
      if (trk !== e.trk) begin
        $error("track_index: expected %0d, got %0d", e.trk, trk);
        errors++;
      end
      if (p !== e.pos) begin
        $error("order_position: expected %0d, got %0d", e.pos, p);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 100000;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [1:0]  opcode = spoe_pkg::OP_RELOAD;
  logic        shuffle_on = 0;
  logic        cfg_write = 0;
  logic [1:0]  cfg_index = spoe_pkg::CFG_LENGTH;
  logic [31:0] cfg_data = '0;
  logic        done;
  logic        status;
  logic [8:0]  track_index;
  logic [8:0]  order_position;

  order_scoreboard sb = new();
  int idle_pct;
  int quiet_cycles;

  shuffle_play_order_engine_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .shuffle_on(shuffle_on), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .status(status), .track_index(track_index),
    .order_position(order_position)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, track_index, order_position);
    if (rst || done || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send(spoe_pkg::opcode_t op, bit sh);
    start <= 1;
    opcode <= op;
    shuffle_on <= sh;
    do @(posedge clk); while (busy);
    sb.note_item(op, sh);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic load_regs(bit [31:0] l, bit [31:0] s, bit [31:0] g, bit [31:0] n);
    bit [31:0] vals[4];
    vals = '{l, s, g, n};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      sb.write_reg(2'(i), vals[i]);
      @(posedge clk);
    end
    cfg_write <= 0;
  endtask

  function automatic bit [31:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(2, 16);
    if (r < 85) return $urandom_range(17, 64);
    if (r < 90) return 1;
    if (r < 93) return 512;
    if (r < 96) return 0;
    return $urandom_range(513, 1023);
  endfunction

  initial begin
    int        count;
    bit [31:0] l;
    bit [31:0] s;
    int        r;
    idle_pct = 29;
    repeat (11) @(posedge clk);
    rst <= 0;

    // Nothing loaded yet: navigation and set-mode are refused; the reload takes the reset length of one.
    send(spoe_pkg::OP_NEXT, 0);
    send(spoe_pkg::OP_PREV, 1);
    send(spoe_pkg::OP_SET_MODE, 1);
    send(spoe_pkg::OP_SET_MODE, 0);
    send(spoe_pkg::OP_RELOAD, 0);
    send(spoe_pkg::OP_PREV, 0);
    send(spoe_pkg::OP_NEXT, 0);
    load_regs(0, 0, 0, 0);
    send(spoe_pkg::OP_RELOAD, 1);
    load_regs(1023, 511, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(spoe_pkg::OP_RELOAD, 0);
    load_regs(5, 5, 32'h8000_0000, 32'h7FFF_FFFF);
    send(spoe_pkg::OP_RELOAD, 0);
    load_regs(512, 511, 32'h7FFF_FFFF, 32'h8000_0000);
    send(spoe_pkg::OP_RELOAD, 0);
    send(spoe_pkg::OP_NEXT, 1);
    send(spoe_pkg::OP_PREV, 0);
    send(spoe_pkg::OP_SET_MODE, 1);
    send(spoe_pkg::OP_PREV, 0);
    send(spoe_pkg::OP_NEXT, 0);
    send(spoe_pkg::OP_SET_MODE, 0);
    load_regs(3, 0, 32'hFFFF_FFFF, 0);
    send(spoe_pkg::OP_RELOAD, 0);
    send(spoe_pkg::OP_SET_MODE, 1);
    send(spoe_pkg::OP_NEXT, 0);
    send(spoe_pkg::OP_NEXT, 0);
    send(spoe_pkg::OP_NEXT, 0);

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 29 : (ph == 1) ? 54 : 0;
      count = 0;
      while (count < 217) begin
        l = pick_length();
        s = (l != 0 && $urandom_range(9) != 0) ? $urandom_range(l - 1) : $urandom_range(511);
        if (l > 512 && $urandom_range(1)) s = $urandom_range(511);
        load_regs(l, s, $urandom, $urandom);
        send(spoe_pkg::OP_RELOAD, $urandom_range(1));
        count++;
        repeat ($urandom_range(4, 20)) begin
          r = $urandom_range(99);
          // Shuffles on long queues are slow, so keep them rare.
          if (r < 12 && (sb.len < 100 || $urandom_range(7) == 0))
            send(spoe_pkg::OP_SET_MODE, $urandom_range(1));
          else if (r < 15)
            send(spoe_pkg::OP_RELOAD, $urandom_range(1));
          else if (r < 60)
            send(spoe_pkg::OP_NEXT, $urandom_range(1));
          else
            send(spoe_pkg::OP_PREV, $urandom_range(1));
          count++;
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
